@@ rtl/core/dmxpd_pkg.sv @@
// ============================================================================
// dmxpd_pkg - shared types and constants of the pixel dimmer and strobe block
// Holds the item and result words, the mode codes, the strobe band limits,
// the half-period table and the per-channel dimmer scaling.
// ============================================================================
package dmxpd_pkg;

    localparam int MAX_UNIVERSES = 8;
    localparam int UNI_PER_STRIP = 4;
    localparam int STRIPS        = 2;

    // Item mode codes; the fourth code is ignored
    localparam logic [1:0] MODE_STROBE = 2'd0;
    localparam logic [1:0] MODE_FRAME  = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;

    // Strobe band limits
    localparam logic [7:0] LEVEL_STEADY_MAX = 8'd10;
    localparam logic [7:0] LEVEL_FULL       = 8'd255;
    localparam logic [7:0] LEVEL_SLOW_MAX   = 8'd128;

    typedef logic [9:0] half_period_t;
    typedef half_period_t [255:0] half_table_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  universe;
        logic [7:0]  strobe_level;
        logic [31:0] now_ms;
        logic [8:0]  keep_a;
        logic [8:0]  keep_b;
        logic        strip_select;
        logic [8:0]  pixel_index;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  blue;
        logic [7:0]  dimmer;
    } item_t;

    typedef struct packed {
        logic        out_strip;
        logic [8:0]  out_pixel;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
    } result_t;

    // Strobe state of one strip as seen by the pixel path
    typedef struct packed {
        logic [7:0] level;
        logic       on;
        logic [8:0] kept;
    } strip_status_t;

    typedef strip_status_t [STRIPS-1:0] strip_status_arr_t;

    // Build half of the strobe period for every level, in ms
    function automatic half_table_t build_half_table();
        half_table_t t;
        int          p;
        for (int i = 0; i < 256; i++)
        begin
            if (i <= 10 || i == 255)
                p = 0;
            else if (i <= 128)
                p = 2000 - ((i - 11) * 1950) / 117;
            else
                p = 2000 - ((i - 129) * 1950) / 125;
            t[i] = half_period_t'(p / 2);
        end
        return t;
    endfunction

    localparam half_table_t HALF_PERIOD = build_half_table();

    function automatic logic is_steady(input logic [7:0] level);
        return (level <= LEVEL_STEADY_MAX) || (level == LEVEL_FULL);
    endfunction

    // Scale a colour byte by dimmer/255, truncating
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] dim);
        logic [15:0] p;
        logic [16:0] s;
        p = 16'(c) * 16'(dim);
        s = {1'b0, p} + 17'(p >> 8) + 17'd1;
        return s[15:8];
    endfunction

endpackage

@@ rtl/core/dmxpd_strobe_ctrl.sv @@
// ============================================================================
// dmxpd_strobe_ctrl - universe strobe bytes and per-strip strobe phase
// Stores the strobe byte of each universe and, on each frame word, takes the
// strip maximum, looks up the half period and advances the strip phase.
// ============================================================================
module dmxpd_strobe_ctrl
    import dmxpd_pkg::*;
#(
    parameter int UNIVERSES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  item_t             item,
    output strip_status_arr_t status
);

    logic [7:0]  universe_reg [MAX_UNIVERSES];
    logic [7:0]  universe_next [MAX_UNIVERSES];
    logic [7:0]  level_reg [STRIPS];
    logic [7:0]  level_next [STRIPS];
    logic [31:0] last_reg [STRIPS];
    logic [31:0] last_next [STRIPS];
    logic        on_reg [STRIPS];
    logic        on_next [STRIPS];
    logic [8:0]  kept_reg [STRIPS];
    logic [8:0]  kept_next [STRIPS];

    logic        strobe_fire;
    logic        frame_fire;
    logic [7:0]  max_level [STRIPS];
    logic [31:0] elapsed [STRIPS];

    assign strobe_fire = fire && (item.mode == MODE_STROBE);
    assign frame_fire  = fire && (item.mode == MODE_FRAME);

    // Take the largest strobe byte of each strip's universes
    always_comb
    begin
        for (int s = 0; s < STRIPS; s++)
        begin
            max_level[s] = 8'd0;
            for (int k = 0; k < UNI_PER_STRIP; k++)
            begin
                if ((s * UNI_PER_STRIP + k) < UNIVERSES &&
                    universe_reg[s * UNI_PER_STRIP + k] > max_level[s])
                    max_level[s] = universe_reg[s * UNI_PER_STRIP + k];
            end
        end
    end

    // Store a strobe byte for a universe in range
    always_comb
    begin
        for (int u = 0; u < MAX_UNIVERSES; u++)
            universe_next[u] = universe_reg[u];
        if (strobe_fire && ({1'b0, item.universe} < 4'(UNIVERSES)))
            universe_next[item.universe] = item.strobe_level;
    end

    // Advance the strip phase on a frame word
    always_comb
    begin
        for (int s = 0; s < STRIPS; s++)
        begin
            level_next[s] = level_reg[s];
            last_next[s]  = last_reg[s];
            on_next[s]    = on_reg[s];
            kept_next[s]  = kept_reg[s];
            elapsed[s]    = item.now_ms - last_reg[s];
            if (frame_fire)
            begin
                level_next[s] = max_level[s];
                kept_next[s]  = (s == 0) ? item.keep_a : item.keep_b;
                if (is_steady(max_level[s]))
                    on_next[s] = 1'b1;
                else if (elapsed[s] >= 32'(HALF_PERIOD[max_level[s]]))
                begin
                    last_next[s] = item.now_ms;
                    on_next[s]   = 1'b1;
                end
                else
                    on_next[s] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < MAX_UNIVERSES; u++)
                universe_reg[u] <= 8'd0;
            for (int s = 0; s < STRIPS; s++)
            begin
                level_reg[s] <= 8'd0;
                last_reg[s]  <= 32'd0;
                on_reg[s]    <= 1'b1;
                kept_reg[s]  <= 9'd0;
            end
        end
        else
        begin
            for (int u = 0; u < MAX_UNIVERSES; u++)
                universe_reg[u] <= universe_next[u];
            for (int s = 0; s < STRIPS; s++)
            begin
                level_reg[s] <= level_next[s];
                last_reg[s]  <= last_next[s];
                on_reg[s]    <= on_next[s];
                kept_reg[s]  <= kept_next[s];
            end
        end
    end

    // Present the strip state to the pixel path
    always_comb
    begin
        for (int s = 0; s < STRIPS; s++)
        begin
            status[s].level = level_reg[s];
            status[s].on    = on_reg[s];
            status[s].kept  = kept_reg[s];
        end
    end

`ifndef SYNTHESIS
    a_steady_on_a: assert property (@(posedge clk) disable iff (!rst_n)
        $past(frame_fire) && is_steady(level_reg[0]) |-> on_reg[0])
        else $error("strip A steady level left phase off");
    a_steady_on_b: assert property (@(posedge clk) disable iff (!rst_n)
        $past(frame_fire) && is_steady(level_reg[1]) |-> on_reg[1])
        else $error("strip B steady level left phase off");
    a_toggle_only_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_fire |=> $stable(last_reg[0]) && $stable(last_reg[1]) &&
                        $stable(level_reg[0]) && $stable(level_reg[1]))
        else $error("strip strobe state changed without a frame word");
    a_universe_only_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe_fire |=> $stable(universe_reg[0]) && $stable(universe_reg[4]))
        else $error("universe strobe byte changed without a strobe word");
`endif

endmodule

@@ rtl/core/dmxpd_pixel_path.sv @@
// ============================================================================
// dmxpd_pixel_path - per-pixel dimming and strobe gating
// Scales green, red and blue by the dimmer byte and gates the colour with
// the strobe band and phase of the pixel's strip.
// ============================================================================
module dmxpd_pixel_path
    import dmxpd_pkg::*;
#(
    parameter int PIXELS_PER_STRIP = 400
)
(
    input  item_t             item,
    input  strip_status_arr_t status,
    output logic              has_result,
    output result_t           result
);

    strip_status_t st;
    logic          in_strip;
    logic          pass;
    logic [7:0]    red_dim;
    logic [7:0]    green_dim;
    logic [7:0]    blue_dim;

    assign st       = status[item.strip_select];
    assign in_strip = {1'b0, item.pixel_index} < 10'(PIXELS_PER_STRIP);

    // Produce a word only for pixel words inside the strip
    assign has_result = (item.mode == MODE_PIXEL) && in_strip;

    // Dim each channel
    assign red_dim   = scale8(item.red, item.dimmer);
    assign green_dim = scale8(item.green, item.dimmer);
    assign blue_dim  = scale8(item.blue, item.dimmer);

    // Gate by strobe band and phase
    always_comb
    begin
        if (is_steady(st.level))
            pass = 1'b1;
        else if (st.level <= LEVEL_SLOW_MAX)
            pass = st.on;
        else
            pass = st.on && (item.pixel_index == st.kept);
    end

    always_comb
    begin
        result.out_strip = item.strip_select;
        result.out_pixel = item.pixel_index;
        result.red_out   = pass ? red_dim : 8'd0;
        result.green_out = pass ? green_dim : 8'd0;
        result.blue_out  = pass ? blue_dim : 8'd0;
    end

endmodule

@@ rtl/core/dmx_pixel_dimmer_strobe.sv @@
// ============================================================================
// dmx_pixel_dimmer_strobe - two-strip pixel dimmer with per-strip strobe
// Strobe words store universe strobe bytes, frame words advance each strip's
// strobe phase, pixel words inside the strip give one dimmed and gated colour word.
//
//   channel  | signals                               | word
//   ---------+---------------------------------------+----------
//   item     | item_valid, item_ready, item          | item_t
//   result   | result_valid, result_ready, result    | result_t
//
// A word accepted on the item channel is held in the input register; its result
// passes the dimmer multiply and gate and is registered in the result register
// as the word leaves the input register, which a stalled result can delay. One
// word is accepted per cycle while results drain.
// Reset clears all strobe bytes, levels and toggle times and sets each strip
// phase on. A stalled result holds the input register only for pixel words
// that give a result; strobe, frame and ignored words pass without waiting.
// ============================================================================
module dmx_pixel_dimmer_strobe
    import dmxpd_pkg::*;
#(
    parameter int PIXELS_PER_STRIP = 400,
    parameter int UNIVERSES        = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    item_t             stage_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;

    logic              stage_fire;
    logic              item_fire;
    logic              has_result;
    result_t           pixel_result;
    strip_status_arr_t status;

    dmxpd_strobe_ctrl #(
        .UNIVERSES (UNIVERSES)
    ) u_strobe_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (stage_fire),
        .item   (stage_reg),
        .status (status)
    );

    dmxpd_pixel_path #(
        .PIXELS_PER_STRIP (PIXELS_PER_STRIP)
    ) u_pixel_path (
        .item       (stage_reg),
        .status     (status),
        .has_result (has_result),
        .result     (pixel_result)
    );

    // Advance the input word unless its result cannot be placed
    assign stage_fire = stage_valid_reg &&
                        (!has_result || !result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || stage_fire;
    assign item_fire  = item_valid && item_ready;

    always_comb
    begin
        if (item_fire)
            stage_valid_next = 1'b1;
        else if (stage_fire)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_comb
    begin
        if (stage_fire && has_result)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
            stage_reg <= item;
        if (stage_fire && has_result)
            result_reg <= pixel_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_fire |-> !item_ready)
        else $error("input accepted while held word is stalled");
    a_pixel_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && has_result |=> result_valid)
        else $error("pixel word left no result");
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |-> !(stage_fire && has_result))
        else $error("pending result overwritten");
`endif

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench - self-checking bench for the two-strip pixel dimmer and strobe
// Drives strobe, frame and pixel words through the valid/ready item channel,
// tracks universe strobe bytes, strip levels and strobe phases in a local
// model, and compares every result word field by field against the oldest
// pending prediction. A short directed table runs first, then random words.
// ============================================================================
module testbench;

    import dmxpd_pkg::*;

    localparam int N_PIXELS         = 400;
    localparam int N_UNIVERSES      = 8;
    localparam int RANDOM_WORDS     = 400;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES      = 20;
    localparam int LIMIT_CYCLES     = 200000;
    localparam int REPORT_MAX       = 10;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        item_t   word;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // Local copy of the strobe state
    logic [7:0]  uni_level   [MAX_UNIVERSES];
    logic [7:0]  strip_level [STRIPS];
    logic [31:0] toggle_ms   [STRIPS];
    logic        strip_on    [STRIPS];
    logic [8:0]  strip_keep  [STRIPS];

    result_t   pending_px[$];
    stim_row_t directed_rows[$];

    int mismatch_count;
    int cycle_count;
    int burst_left;
    bit hold_request;

    dmx_pixel_dimmer_strobe #(
        .PIXELS_PER_STRIP(N_PIXELS),
        .UNIVERSES       (N_UNIVERSES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // Run the clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("dmx_pixel_dimmer_strobe: mismatch");
            $finish;
        end
    end

    function automatic item_t strobe_word(input int uni, input int lvl);
        item_t w;
        w = '0;
        w.mode         = MODE_STROBE;
        w.universe     = 3'(uni);
        w.strobe_level = 8'(lvl);
        return w;
    endfunction

    function automatic item_t frame_word(input logic [31:0] now, input int ka, input int kb);
        item_t w;
        w = '0;
        w.mode   = MODE_FRAME;
        w.now_ms = now;
        w.keep_a = 9'(ka);
        w.keep_b = 9'(kb);
        return w;
    endfunction

    function automatic item_t pixel_word(input int s, input int px, input int g, input int r,
                                         input int b, input int d);
        item_t w;
        w = '0;
        w.mode         = MODE_PIXEL;
        w.strip_select = 1'(s);
        w.pixel_index  = 9'(px);
        w.green        = 8'(g);
        w.red          = 8'(r);
        w.blue         = 8'(b);
        w.dimmer       = 8'(d);
        return w;
    endfunction

    function automatic result_t pixel_result(input int s, input int px, input int r,
                                             input int g, input int b);
        result_t o;
        o.out_strip = 1'(s);
        o.out_pixel = 9'(px);
        o.red_out   = 8'(r);
        o.green_out = 8'(g);
        o.blue_out  = 8'(b);
        return o;
    endfunction

    function automatic logic [7:0] dim_byte(input logic [7:0] c, input logic [7:0] d);
        return 8'((int'(c) * int'(d)) / 255);
    endfunction

    // Half of the strobe period in ms for a level in one of the two blink bands
    function automatic int half_period_ms(input logic [7:0] lvl);
        int v;
        int period;
        v = int'(lvl);
        if (lvl <= LEVEL_SLOW_MAX)
            period = 2000 - ((v - 11) * 1950) / 117;
        else
            period = 2000 - ((v - 129) * 1950) / 125;
        return period / 2;
    endfunction

    // Apply one accepted word to the strobe state; give the pixel it yields
    task automatic track_strobe_and_dim(input item_t w, output bit has_px, output result_t px);
        logic [7:0]  top;
        logic [31:0] elapsed;
        logic [7:0]  lvl;
        logic        lit;
        int          u;
        int          s;
        has_px = 1'b0;
        px     = '0;
        case (w.mode)
            MODE_STROBE:
            begin
                if (int'(w.universe) < N_UNIVERSES)
                    uni_level[w.universe] = w.strobe_level;
            end
            MODE_FRAME:
            begin
                strip_keep[0] = w.keep_a;
                strip_keep[1] = w.keep_b;
                for (s = 0; s < STRIPS; s++)
                begin
                    top = 8'd0;
                    for (int k = 0; k < UNI_PER_STRIP; k++)
                    begin
                        u = s * UNI_PER_STRIP + k;
                        if (u < N_UNIVERSES && uni_level[u] > top)
                            top = uni_level[u];
                    end
                    strip_level[s] = top;
                    if (top <= LEVEL_STEADY_MAX || top == LEVEL_FULL)
                        strip_on[s] = 1'b1;
                    else
                    begin
                        elapsed = w.now_ms - toggle_ms[s];
                        if (elapsed >= 32'(half_period_ms(top)))
                        begin
                            toggle_ms[s] = w.now_ms;
                            strip_on[s]  = 1'b1;
                        end
                        else
                            strip_on[s] = 1'b0;
                    end
                end
            end
            MODE_PIXEL:
            begin
                s   = int'(w.strip_select);
                lvl = strip_level[s];
                if (int'(w.pixel_index) < N_PIXELS)
                begin
                    if (lvl <= LEVEL_STEADY_MAX || lvl == LEVEL_FULL)
                        lit = 1'b1;
                    else if (lvl <= LEVEL_SLOW_MAX)
                        lit = strip_on[s];
                    else
                        lit = strip_on[s] && (w.pixel_index == strip_keep[s]);
                    has_px       = 1'b1;
                    px.out_strip = w.strip_select;
                    px.out_pixel = w.pixel_index;
                    px.red_out   = lit ? dim_byte(w.red, w.dimmer) : 8'd0;
                    px.green_out = lit ? dim_byte(w.green, w.dimmer) : 8'd0;
                    px.blue_out  = lit ? dim_byte(w.blue, w.dimmer) : 8'd0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_row(input item_t w, input bit typed, input result_t want);
        stim_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Offer one word in bursts with random gaps; track it once accepted
    task automatic send_word(input item_t w, input bit typed, input result_t want);
        bit      has_px;
        result_t px;
        int      gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        track_strobe_and_dim(w, has_px, px);
        if (has_px)
            pending_px.push_back(typed ? want : px);
        @(negedge clk);
    endtask

    // Stall the result channel on its own pattern, with one long hold on request
    initial
    begin : result_drain
        int pattern;
        int pattern_left;
        int held;
        bit flip;
        pattern      = 0;
        pattern_left = 0;
        flip         = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_request = 1'b0;
            end
            if (pattern_left == 0)
            begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 64);
            end
            pattern_left--;
            flip = !flip;
            case (pattern)
                0:       result_ready <= 1'b1;
                1:       result_ready <= flip;
                2:       result_ready <= 1'($urandom_range(0, 1));
                default: result_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_px.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected pixel word: strip %0d px %0d rgb %02h %02h %02h",
                             result.out_strip, result.out_pixel,
                             result.red_out, result.green_out, result.blue_out);
            end
            else
            begin
                want = pending_px.pop_front();
                if (want.out_strip !== result.out_strip || want.out_pixel !== result.out_pixel
                    || want.red_out !== result.red_out || want.green_out !== result.green_out
                    || want.blue_out !== result.blue_out)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"pixel word differs: want %0d/%0d %02h %02h %02h, ",
                                  "got %0d/%0d %02h %02h %02h"},
                                 want.out_strip, want.out_pixel,
                                 want.red_out, want.green_out, want.blue_out,
                                 result.out_strip, result.out_pixel,
                                 result.red_out, result.green_out, result.blue_out);
                end
            end
        end
    end

    initial
    begin : stimulus
        item_t       w;
        item_t       noise;
        logic [127:0] rnd;
        logic [31:0] clock_ms;
        logic [7:0]  band_edges [7];
        int          pick;
        int          s;
        int          px;

        band_edges     = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd129, 8'd254, 8'd255};
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        clock_ms       = 32'd100;
        item           = '0;
        item_valid     = 1'b0;
        rst_n          = 1'b0;
        for (int u = 0; u < MAX_UNIVERSES; u++)
            uni_level[u] = 8'd0;
        for (int k = 0; k < STRIPS; k++)
        begin
            strip_level[k] = 8'd0;
            toggle_ms[k]   = 32'd0;
            strip_on[k]    = 1'b1;
            strip_keep[k]  = 9'd0;
        end

        // Directed table: after reset, extremes, ignored words, band edges, wrap
        add_row(pixel_word(0, 0, 255, 255, 255, 255), 1'b1, pixel_result(0, 0, 255, 255, 255));
        add_row(pixel_word(1, 399, 170, 255, 85, 0), 1'b1, pixel_result(1, 399, 0, 0, 0));
        add_row(pixel_word(0, 400, 255, 255, 255, 255), 1'b0, '0);
        add_row(pixel_word(1, 511, 255, 255, 255, 255), 1'b0, '0);
        add_row('1, 1'b0, '0);
        add_row(strobe_word(0, 11), 1'b0, '0);
        add_row(frame_word(32'd0, 0, 0), 1'b0, '0);
        add_row(pixel_word(0, 5, 200, 100, 50, 255), 1'b1, pixel_result(0, 5, 0, 0, 0));
        add_row(pixel_word(1, 5, 200, 100, 50, 128), 1'b0, '0);
        add_row(frame_word(32'd1000, 0, 0), 1'b0, '0);
        add_row(pixel_word(0, 5, 1, 254, 127, 254), 1'b0, '0);
        add_row(strobe_word(5, 129), 1'b0, '0);
        add_row(strobe_word(6, 254), 1'b0, '0);
        add_row(frame_word(32'hFFFF_FFFF, 3, 7), 1'b0, '0);
        add_row(pixel_word(1, 7, 90, 180, 240, 200), 1'b0, '0);
        add_row(pixel_word(1, 6, 90, 180, 240, 200), 1'b1, pixel_result(1, 6, 0, 0, 0));
        add_row(frame_word(32'd10, 0, 511), 1'b0, '0);
        add_row(pixel_word(0, 0, 255, 255, 255, 255), 1'b1, pixel_result(0, 0, 0, 0, 0));
        add_row(frame_word(32'd24, 0, 511), 1'b0, '0);
        add_row(pixel_word(1, 0, 255, 255, 255, 255), 1'b1, pixel_result(1, 0, 0, 0, 0));
        add_row(strobe_word(3, 255), 1'b0, '0);
        add_row(strobe_word(4, 128), 1'b0, '0);
        add_row(strobe_word(1, 10), 1'b0, '0);
        add_row(frame_word(32'd50, 0, 0), 1'b0, '0);
        add_row(pixel_word(0, 399, 255, 255, 255, 255), 1'b1,
                pixel_result(0, 399, 255, 255, 255));

        // Hold reset, release on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Random words: mostly pixels, with strobe and frame words mixed in
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 120)
                hold_request = 1'b1;
            if (i == 260)
            begin
                // Drain everything before offering more
                item_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_px.size() != 0);
            end
            rnd   = {$urandom, $urandom, $urandom, $urandom};
            noise = rnd[$bits(item_t)-1:0];
            w     = noise;
            pick  = $urandom_range(0, 99);
            if (pick < 12)
            begin
                w.mode = MODE_STROBE;
                if ($urandom_range(0, 99) < 40)
                    w.strobe_level = band_edges[$urandom_range(0, 6)];
            end
            else if (pick < 26)
            begin
                w.mode = MODE_FRAME;
                if ($urandom_range(0, 99) < 10)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + 32'($urandom_range(0, 1100));
                w.now_ms = clock_ms;
                w.keep_a = ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 399))
                                                         : 9'($urandom_range(400, 511));
                w.keep_b = ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 399))
                                                         : 9'($urandom_range(400, 511));
            end
            else if (pick < 29)
                w.mode = MODE_UNUSED;
            else
            begin
                w.mode = MODE_PIXEL;
                s      = int'(w.strip_select);
                pick   = $urandom_range(0, 99);
                if (pick < 30)
                    px = int'(strip_keep[s]);
                else if (pick < 38)
                    px = $urandom_range(400, 511);
                else
                    px = $urandom_range(0, 399);
                w.pixel_index = 9'(px);
                if ($urandom_range(0, 99) < 20)
                    w.dimmer = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            end
            send_word(w, 1'b0, '0);
        end

        // Drain and let the pipeline settle
        item_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_px.size() == 0)
            $display("dmx_pixel_dimmer_strobe: match");
        else
            $display("dmx_pixel_dimmer_strobe: mismatch");
        $finish;
    end

endmodule

@@ dmx_pixel_dimmer_strobe.f @@
rtl/core/dmxpd_pkg.sv
rtl/core/dmxpd_strobe_ctrl.sv
rtl/core/dmxpd_pixel_path.sv
rtl/core/dmx_pixel_dimmer_strobe.sv
tb/testbench.sv
